[hdl/rmq2d_pkg.sv]
// Shared types and constants for the 2-D sparse table range-maximum block.
package rmq2d_pkg;
	localparam int MaxRows   = 32;
	localparam int MaxCols   = 32;
	localparam int ValueBits = 32;
	localparam int RowLevels = $clog2(MaxRows) + 1;
	localparam int ColLevels = $clog2(MaxCols) + 1;
	localparam int RowBits   = $clog2(MaxRows);
	localparam int ColBits   = $clog2(MaxCols);
	localparam int PBits     = $clog2(RowLevels);
	localparam int QBits     = $clog2(ColLevels);
	localparam int AddrBits  = PBits + QBits + RowBits + ColBits;
	localparam int Depth     = 1 << AddrBits;
	localparam int DimBits   = 6;

	typedef logic [1:0] func_t;
	localparam func_t FuncLoad  = 2'd0;
	localparam func_t FuncBuild = 2'd1;
	localparam func_t FuncQuery = 2'd2;

	typedef logic [1:0] status_t;
	localparam status_t StatusOk       = 2'd0;
	localparam status_t StatusBadRect  = 2'd1;
	localparam status_t StatusNotBuilt = 2'd2;

	localparam logic AddrRows = 1'b0;
	localparam logic AddrCols = 1'b1;

	typedef logic [AddrBits-1:0] addr_t;
	typedef logic signed [ValueBits-1:0] value_t;

	function automatic addr_t tab_addr(input logic [PBits-1:0] p, input logic [QBits-1:0] q,
			input logic [RowBits-1:0] r, input logic [ColBits-1:0] c);
		tab_addr = {p, q, r, c};
	endfunction

	function automatic logic [DimBits-1:0] clamp_dim(input logic [DimBits-1:0] v,
			input logic [DimBits-1:0] mx);
		if (v == '0)
			clamp_dim = DimBits'(1);
		else if (v > mx)
			clamp_dim = mx;
		else
			clamp_dim = v;
	endfunction

	function automatic logic [3:0] floor_log2(input logic [DimBits-1:0] x);
		logic [3:0] r;
		r = '0;
		for (int k = 0; k < DimBits; k++)
			if (x[k])
				r = 4'(k);
		floor_log2 = r;
	endfunction
endpackage

[hdl/rmq2d_ram.sv]
// Generic single-port RAM with registered read.
module rmq2d_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

[hdl/range_max_query_2d_sparse_table_core.sv]
// Top level: 2-D sparse table range-maximum engine with APB configuration.
// A load writes its cell, if it lies inside the table, straight from the accepted beat. A
// query is set up when it is accepted, then makes four reads through the single table port
// (states QRD, QCMP), and its result waits in the output register until the beat leaves;
// a rejected query goes straight to the output register. A build reads two entries and writes
// one per table entry (states BRD0, BRD1, BWR), for up to (levels x levels x rows x cols)
// entries, all through the one memory port. tready is low while an item is in work or a
// result waits; the result register sits on the master side.
module range_max_query_2d_sparse_table_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // func, row_first, col_first, row_last, col_last, cell_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // max_value, status, zero pad
);
	typedef enum logic [2:0] {
		IDLE, QRD, QCMP, BRD0, BRD1, BWR, OUTW
	} state_t;

	state_t state_q;
	logic [rmq2d_pkg::DimBits-1:0] rows_q, cols_q;
	logic built_q;
	logic [rmq2d_pkg::PBits-1:0] p_q;
	logic [rmq2d_pkg::QBits-1:0] q_q;
	logic [rmq2d_pkg::RowBits:0] i_q;
	logic [rmq2d_pkg::ColBits:0] j_q;
	logic [2:0] rd_cnt_q;
	logic [rmq2d_pkg::RowBits-1:0] r1_q, rb_q;
	logic [rmq2d_pkg::ColBits-1:0] c1_q, cb_q;
	rmq2d_pkg::value_t best_q, a_q;
	rmq2d_pkg::value_t max_value_q;
	rmq2d_pkg::status_t status_q;
	logic out_q;

	logic we;
	rmq2d_pkg::addr_t addr;
	rmq2d_pkg::value_t wdata, rdata;

	rmq2d_ram #(.Width(rmq2d_pkg::ValueBits), .Depth(rmq2d_pkg::Depth)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	logic [1:0] in_func;
	logic [4:0] in_r1, in_c1, in_r2, in_c2;
	logic [31:0] in_val;
	assign in_func = s_tdata[1:0];
	assign in_r1 = s_tdata[6:2];
	assign in_c1 = s_tdata[11:7];
	assign in_r2 = s_tdata[16:12];
	assign in_c2 = s_tdata[21:17];
	assign in_val = s_tdata[53:22];

	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_comb begin
		prdata = '0;
		if (paddr[2] == rmq2d_pkg::AddrRows)
			prdata = 32'(rows_q);
		else
			prdata = 32'(cols_q);
		if (paddr[1:0] != 2'b00 || paddr[2] != rmq2d_pkg::AddrRows && paddr[2] != rmq2d_pkg::AddrCols)
			prdata = '0;
	end

	logic s_fire;
	assign s_tready = state_q == IDLE && !out_q;
	assign s_fire = s_tvalid && s_tready;
	assign m_tvalid = out_q;
	assign m_tdata = {6'd0, status_q, max_value_q};

	// query decode
	logic [rmq2d_pkg::DimBits-1:0] h, w;
	logic [3:0] lp, lq;
	logic bad;
	assign h = rmq2d_pkg::DimBits'(in_r2) - rmq2d_pkg::DimBits'(in_r1) + 1'b1;
	assign w = rmq2d_pkg::DimBits'(in_c2) - rmq2d_pkg::DimBits'(in_c1) + 1'b1;
	assign lp = rmq2d_pkg::floor_log2(h);
	assign lq = rmq2d_pkg::floor_log2(w);
	assign bad = in_r1 > in_r2 || in_c1 > in_c2 || 6'(in_r2) >= rows_q || 6'(in_c2) >= cols_q;

	// build walk bounds
	logic [rmq2d_pkg::DimBits:0] hp, wq;
	logic [rmq2d_pkg::RowBits-1:0] i_lo;
	logic [rmq2d_pkg::ColBits-1:0] j_lo;
	assign hp = 7'(1) << p_q;
	assign wq = 7'(1) << q_q;
	assign i_lo = i_q[rmq2d_pkg::RowBits-1:0];
	assign j_lo = j_q[rmq2d_pkg::ColBits-1:0];

	logic [rmq2d_pkg::RowBits-1:0] qr;
	logic [rmq2d_pkg::ColBits-1:0] qc;
	always_comb begin
		unique case (rd_cnt_q[1:0])
			2'd0: begin qr = r1_q; qc = c1_q; end
			2'd1: begin qr = r1_q; qc = cb_q; end
			2'd2: begin qr = rb_q; qc = c1_q; end
			default: begin qr = rb_q; qc = cb_q; end
		endcase
	end

	always_comb begin
		we = 1'b0;
		wdata = '0;
		addr = rmq2d_pkg::tab_addr('0, '0, in_r1, in_c1);
		unique case (state_q)
			IDLE: begin
				we = s_fire && in_func == rmq2d_pkg::FuncLoad && 6'(in_r1) < rows_q
					&& 6'(in_c1) < cols_q;
				wdata = in_val;
			end
			QRD, QCMP: addr = rmq2d_pkg::tab_addr(p_q, q_q, qr, qc);
			BRD0: begin
				if (p_q != '0)
					addr = rmq2d_pkg::tab_addr(p_q - 1'b1, q_q, i_lo, j_lo);
				else
					addr = rmq2d_pkg::tab_addr(p_q, q_q - 1'b1, i_lo, j_lo);
			end
			BRD1: begin
				if (p_q != '0)
					addr = rmq2d_pkg::tab_addr(p_q - 1'b1, q_q,
						i_lo + rmq2d_pkg::RowBits'(hp >> 1), j_lo);
				else
					addr = rmq2d_pkg::tab_addr(p_q, q_q - 1'b1, i_lo,
						j_lo + rmq2d_pkg::ColBits'(wq >> 1));
			end
			BWR: begin
				we = 1'b1;
				wdata = (a_q > rdata) ? a_q : rdata;
				addr = rmq2d_pkg::tab_addr(p_q, q_q, i_lo, j_lo);
			end
			default: ;
		endcase
	end

	// next build coordinate (skips level 0,0 and levels that do not fit)
	logic j_end, i_end, q_end;
	assign j_end = 7'(j_q) + 7'd1 + wq > 7'(cols_q);
	assign i_end = 7'(i_q) + 7'd1 + hp > 7'(rows_q);
	assign q_end = (7'(1) << (q_q + 1'b1)) > 7'(cols_q) || 32'(q_q) + 1 >= rmq2d_pkg::ColLevels;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			rows_q <= 6'd32;
			cols_q <= 6'd32;
			built_q <= 1'b0;
			out_q <= 1'b0;
			p_q <= '0; q_q <= '0; i_q <= '0; j_q <= '0; rd_cnt_q <= '0;
		end else begin
			if (m_tvalid && m_tready)
				out_q <= 1'b0;
			if (cfg_wr && paddr == 3'd0) begin
				rows_q <= rmq2d_pkg::clamp_dim(pwdata[5:0], 6'(rmq2d_pkg::MaxRows));
				built_q <= 1'b0;
			end else if (cfg_wr && paddr == 3'd4) begin
				cols_q <= rmq2d_pkg::clamp_dim(pwdata[5:0], 6'(rmq2d_pkg::MaxCols));
				built_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: if (s_fire) begin
					if (we)
						built_q <= 1'b0;
					if (in_func == rmq2d_pkg::FuncBuild) begin
						p_q <= '0; q_q <= '0; i_q <= '0; j_q <= '0;
						if (cols_q >= 6'd2) begin
							q_q <= rmq2d_pkg::QBits'(1);
							state_q <= BRD0;
						end else if (rows_q >= 6'd2) begin
							p_q <= rmq2d_pkg::PBits'(1);
							state_q <= BRD0;
						end else
							built_q <= 1'b1;
					end else if (in_func == rmq2d_pkg::FuncQuery) begin
						max_value_q <= '0;
						if (!built_q) begin
							status_q <= rmq2d_pkg::StatusNotBuilt;
							out_q <= 1'b1;
						end else if (bad) begin
							status_q <= rmq2d_pkg::StatusBadRect;
							out_q <= 1'b1;
						end else begin
							status_q <= rmq2d_pkg::StatusOk;
							p_q <= rmq2d_pkg::PBits'(lp);
							q_q <= rmq2d_pkg::QBits'(lq);
							r1_q <= in_r1; c1_q <= in_c1;
							rb_q <= 5'(6'(in_r2) + 6'd1 - (6'd1 << lp));
							cb_q <= 5'(6'(in_c2) + 6'd1 - (6'd1 << lq));
							rd_cnt_q <= '0;
							state_q <= QRD;
						end
					end
				end
				QRD: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					state_q <= QCMP;
				end
				QCMP: begin
					if (rd_cnt_q == 3'd1 || rdata > best_q)
						best_q <= rdata;
					rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_cnt_q == 3'd4) begin
						max_value_q <= (rd_cnt_q == 3'd1 || rdata > best_q) ? rdata : best_q;
						out_q <= 1'b1;
						state_q <= IDLE;
					end
				end
				BRD0: state_q <= BRD1;
				BRD1: begin
					a_q <= rdata;
					state_q <= BWR;
				end
				BWR: begin
					state_q <= BRD0;
					if (!j_end)
						j_q <= j_q + 1'b1;
					else if (!i_end) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else begin
						i_q <= '0; j_q <= '0;
						if (!q_end)
							q_q <= q_q + 1'b1;
						else if ((7'(1) << (p_q + 1'b1)) <= 7'(rows_q)
								&& 32'(p_q) + 1 < rmq2d_pkg::RowLevels) begin
							p_q <= p_q + 1'b1;
							q_q <= '0;
						end else begin
							built_q <= 1'b1;
							state_q <= IDLE;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) s_tready |-> !out_q)
		else $error("accept while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BWR |=> state_q == BRD0 || state_q == IDLE)
		else $error("build walk left its loop");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_q && status_q != rmq2d_pkg::StatusOk |-> max_value_q == '0)
		else $error("error result carries data");
endmodule
